// ----- rtl/core/glyph_cache_lru_directory_unit_macros.svh -----
// ---------------------------------------------------------------------------
// glyph cache lru directory assertion macros
// shared concurrent assertion forms for the directory checker
// ---------------------------------------------------------------------------
`ifndef GLYPH_CACHE_LRU_DIRECTORY_UNIT_MACROS_SVH
`define GLYPH_CACHE_LRU_DIRECTORY_UNIT_MACROS_SVH

// same-cycle implication
`define GCLD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcld assertion failed");

// next-cycle implication
`define GCLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcld assertion failed");

`endif

// ----- rtl/core/gcld_pkg.sv -----
// ---------------------------------------------------------------------------
// gcld_pkg
// types, constants and codes of the glyph cache lru directory
// ---------------------------------------------------------------------------
package gcld_pkg;

    localparam int CACHE_SLOTS = 16;
    localparam int STAMP_BITS  = 32;
    localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int COUNT_W     = $clog2(CACHE_SLOTS + 1);
    localparam int CFG_W       = 5;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 32;

    localparam logic [2:0] OUT_HIT      = 3'd0;
    localparam logic [2:0] OUT_FILLED   = 3'd1;
    localparam logic [2:0] OUT_ABSENT   = 3'd2;
    localparam logic [2:0] OUT_UNCACHED = 3'd3;
    localparam logic [2:0] OUT_CLEARED  = 3'd4;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0]         cp;
        logic [COUNT_W-1:0]  used;
        logic [COUNT_W-1:0]  size;
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_slot;
        logic [15:0]         wr_tag;
        logic [STAMP_BITS-1:0] wr_stamp;
    } bcast_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     hit_idx;
        logic                  old_valid;
        logic [STAMP_BITS-1:0] old_stamp;
        logic [SLOT_W-1:0]     old_idx;
    } link_t;

endpackage

// ----- rtl/core/gcld_cell.sv -----
// ---------------------------------------------------------------------------
// gcld_cell
// one directory slot: tag and stamp storage, plus a registered chain stage
// carrying the first match and the oldest stamp seen so far
// ---------------------------------------------------------------------------
module gcld_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gcld_pkg::SLOT_W-1:0] cell_index,
    input  gcld_pkg::bcast_t            bcast,
    input  gcld_pkg::link_t             link_in,
    output gcld_pkg::link_t             link_out
);

    logic [15:0]                       tag_reg;
    logic [gcld_pkg::STAMP_BITS-1:0]   stamp_reg;
    gcld_pkg::link_t                   link_reg;
    gcld_pkg::link_t                   link_next;
    logic                              in_used;
    logic                              in_size;
    logic                              own_match;
    logic                              take_own;

    always_ff @(posedge clk)
    begin
        if (bcast.wr_en && (bcast.wr_slot == cell_index))
        begin
            tag_reg   <= bcast.wr_tag;
            stamp_reg <= bcast.wr_stamp;
        end
    end

    always_comb
    begin
        in_used   = gcld_pkg::COUNT_W'(cell_index) < bcast.used;
        in_size   = gcld_pkg::COUNT_W'(cell_index) < bcast.size;
        own_match = in_used && (tag_reg == bcast.cp);
        take_own  = in_size && (!link_in.old_valid || (stamp_reg < link_in.old_stamp));

        link_next.hit       = link_in.hit || own_match;
        link_next.hit_idx   = link_in.hit ? link_in.hit_idx : cell_index;
        link_next.old_valid = link_in.old_valid || in_size;
        link_next.old_stamp = take_own ? stamp_reg : link_in.old_stamp;
        link_next.old_idx   = take_own ? cell_index : link_in.old_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ----- rtl/core/glyph_cache_lru_directory_unit.sv -----
// ---------------------------------------------------------------------------
// glyph_cache_lru_directory_unit
// fully associative lru tag directory for a glyph cache, built as a chain
// of slot cells with a registered match and oldest-stamp sweep
// ---------------------------------------------------------------------------
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+------------------------------------
//  request   | start, busy                       | mode, codepoint, now_ms, glyph_found
//  result    | done (one-cycle strobe)           | outcome, slot, hit_total, miss_total
//  config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  the result strobe is registered from the decide state: a one-cell-per-cycle match
//  and oldest-stamp sweep runs first, then the decide-and-write state (ST_DONE).
//  busy is high from the cycle after the transfer through the decide cycle, so the
//  next transfer can come in the strobe cycle.
//  reset empties the directory, zeroes the counters and sets the slot limit to 16.
//  results cannot be stalled; the strobe lasts exactly one cycle.
// ---------------------------------------------------------------------------
module glyph_cache_lru_directory_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [15:0]                   codepoint,
    input  logic [31:0]                   now_ms,
    input  logic                          glyph_found,
    output logic                          done,
    output logic [2:0]                    outcome,
    output logic [3:0]                    slot,
    output logic [31:0]                   hit_total,
    output logic [31:0]                   miss_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcld_pkg::ADDR_W-1:0]   paddr,
    input  logic [gcld_pkg::DATA_W-1:0]   pwdata,
    output logic [gcld_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    gcld_pkg::state_t                 state_reg;
    gcld_pkg::state_t                 state_next;
    logic [gcld_pkg::SLOT_W-1:0]      sweep_cnt_reg;
    logic [gcld_pkg::SLOT_W-1:0]      sweep_cnt_next;
    logic [gcld_pkg::CFG_W-1:0]       slots_reg;
    logic [gcld_pkg::COUNT_W-1:0]     filled_reg;
    logic [gcld_pkg::COUNT_W-1:0]     filled_next;
    logic [gcld_pkg::CNT_W-1:0]       hit_cnt_reg;
    logic [gcld_pkg::CNT_W-1:0]       hit_cnt_next;
    logic [gcld_pkg::CNT_W-1:0]       miss_cnt_reg;
    logic [gcld_pkg::CNT_W-1:0]       miss_cnt_next;
    logic                             done_reg;
    logic [2:0]                       outcome_reg;
    logic [2:0]                       outcome_next;
    logic [3:0]                       slot_reg;
    logic [gcld_pkg::SLOT_W-1:0]      slot_next;
    logic                             mode_reg;
    logic [15:0]                      cp_reg;
    logic [gcld_pkg::STAMP_BITS-1:0]  stamp_reg;
    logic                             found_reg;
    logic [gcld_pkg::COUNT_W-1:0]     size;
    logic [gcld_pkg::COUNT_W-1:0]     used;
    logic                             wr_en;
    logic                             accept;
    logic                             cfg_write;
    gcld_pkg::bcast_t                 bcast;
    gcld_pkg::link_t                  link [gcld_pkg::CACHE_SLOTS+1];
    gcld_pkg::link_t                  tail;

    localparam logic [gcld_pkg::SLOT_W-1:0] SWEEP_LAST =
        gcld_pkg::SLOT_W'(gcld_pkg::CACHE_SLOTS - 1);

    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == gcld_pkg::REG_SLOTS_IN_USE);
    assign prdata    = (paddr[2] == gcld_pkg::REG_SLOTS_IN_USE)
                       ? gcld_pkg::DATA_W'(slots_reg) : '0;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= gcld_pkg::SLOTS_RESET;
        end
        else if (cfg_write)
        begin
            slots_reg <= pwdata[gcld_pkg::CFG_W-1:0];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            cp_reg    <= codepoint;
            stamp_reg <= now_ms[gcld_pkg::STAMP_BITS-1:0];
            found_reg <= glyph_found;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            gcld_pkg::ST_IDLE:
            begin
                sweep_cnt_next = '0;
                if (start)
                begin
                    state_next = gcld_pkg::ST_SWEEP;
                end
            end
            gcld_pkg::ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    state_next = gcld_pkg::ST_DONE;
                end
            end
            gcld_pkg::ST_DONE:
            begin
                state_next = gcld_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gcld_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and directory decision
    always_comb
    begin
        busy = (state_reg != gcld_pkg::ST_IDLE);
        size = (int'(slots_reg) > gcld_pkg::CACHE_SLOTS)
               ? gcld_pkg::COUNT_W'(gcld_pkg::CACHE_SLOTS)
               : gcld_pkg::COUNT_W'(slots_reg);
        used = (filled_reg < size) ? filled_reg : size;

        filled_next   = filled_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        slot_next     = '0;
        wr_en         = 1'b0;
        outcome_next  = gcld_pkg::OUT_CLEARED;

        if (mode_reg == gcld_pkg::MODE_CLEAR)
        begin
            filled_next  = '0;
            outcome_next = gcld_pkg::OUT_CLEARED;
        end
        else if (tail.hit)
        begin
            slot_next    = tail.hit_idx;
            wr_en        = 1'b1;
            hit_cnt_next = hit_cnt_reg + 1'b1;
            outcome_next = gcld_pkg::OUT_HIT;
        end
        else if (!found_reg)
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
            outcome_next  = gcld_pkg::OUT_ABSENT;
        end
        else if (size == '0)
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
            outcome_next  = gcld_pkg::OUT_UNCACHED;
        end
        else
        begin
            if (used < size)
            begin
                slot_next   = gcld_pkg::SLOT_W'(used);
                filled_next = used + 1'b1;
            end
            else
            begin
                slot_next = tail.old_idx;
            end
            wr_en         = 1'b1;
            miss_cnt_next = miss_cnt_reg + 1'b1;
            outcome_next  = gcld_pkg::OUT_FILLED;
        end

        if (state_reg != gcld_pkg::ST_DONE)
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcld_pkg::ST_IDLE;
            sweep_cnt_reg <= '0;
            filled_reg    <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= (state_reg == gcld_pkg::ST_DONE);
            if (state_reg == gcld_pkg::ST_DONE)
            begin
                filled_reg   <= filled_next;
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gcld_pkg::ST_DONE)
        begin
            outcome_reg <= outcome_next;
            slot_reg    <= 4'(slot_next);
        end
    end

    assign done       = done_reg;
    assign outcome    = outcome_reg;
    assign slot       = slot_reg;
    assign hit_total  = hit_cnt_reg;
    assign miss_total = miss_cnt_reg;

    // broadcast to the cell chain
    assign bcast.cp       = cp_reg;
    assign bcast.used     = used;
    assign bcast.size     = size;
    assign bcast.wr_en    = wr_en;
    assign bcast.wr_slot  = slot_next;
    assign bcast.wr_tag   = cp_reg;
    assign bcast.wr_stamp = stamp_reg;

    assign link[0] = '0;
    assign tail    = link[gcld_pkg::CACHE_SLOTS];

    for (genvar g = 0; g < gcld_pkg::CACHE_SLOTS; g++)
    begin : g_cell
        gcld_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (gcld_pkg::SLOT_W'(g)),
            .bcast      (bcast),
            .link_in    (link[g]),
            .link_out   (link[g+1])
        );
    end

endmodule

// ----- rtl/core/gcld_checker.sv -----
// ---------------------------------------------------------------------------
// gcld_checker
// port-level checks on the directory request and result sequencing
// ---------------------------------------------------------------------------
`include "glyph_cache_lru_directory_unit_macros.svh"

module gcld_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] outcome,
    input logic [3:0] slot
);

    logic no_slot_outcome;

    assign no_slot_outcome = (outcome == gcld_pkg::OUT_CLEARED)
                             || (outcome == gcld_pkg::OUT_ABSENT)
                             || (outcome == gcld_pkg::OUT_UNCACHED);

    `GCLD_ASSERT_NEXT(a_transfer_sets_busy, start && !busy, busy)
    `GCLD_ASSERT_SAME(a_done_after_busy, done, $past(busy) && !busy)
    `GCLD_ASSERT_NEXT(a_single_strobe, done, !done)
    `GCLD_ASSERT_SAME(a_slot_zero_no_slot, done && no_slot_outcome, slot == 4'd0)

endmodule

bind glyph_cache_lru_directory_unit gcld_checker u_gcld_checker (.*);
